FILE: design/bac_pkg.sv
// shared types, constants and the conflict function for the button autorepeat core
// no dependencies
`default_nettype none

package bac_pkg;

  // action count default
  localparam int ACTION_COUNT_DEF = 8;

  // field widths
  localparam int TIME_W    = 32;
  localparam int DELAY_W   = 16;
  localparam int MASK_W    = 4;
  localparam int PRESS_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // register reset values (0.5 s, 0.15 s in ms)
  localparam logic [DELAY_W-1:0] INIT_DELAY_RST = 16'd500;
  localparam logic [DELAY_W-1:0] REPEAT_IVL_RST = 16'd150;
  localparam logic [MASK_W-1:0]  CONFLICT_RST   = 4'd7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_IVL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFLICT   = 2'd2;

  // action positions
  localparam int ACT_ACCEPT = 0;
  localparam int ACT_BACK   = 1;
  localparam int ACT_UP     = 2;
  localparam int ACT_DOWN   = 3;
  localparam int ACT_LEFT   = 4;
  localparam int ACT_RIGHT  = 5;
  localparam int ACT_START  = 6;

  // conflict mask bits
  localparam int CM_UP_DOWN     = 0;
  localparam int CM_LEFT_RIGHT  = 1;
  localparam int CM_ACCEPT_BACK = 2;
  localparam int CM_ACCEPT_START = 3;

  // common control seen by every action lane
  typedef struct packed {
    logic                 upd;
    logic                 rearm;
    logic                 active;
    logic [TIME_W-1:0]    now;
    logic [DELAY_W-1:0]   init_delay;
    logic [DELAY_W-1:0]   repeat_ivl;
  } bac_lane_ctl_t;

  // per-action suppression from this frame's pressed bits
  function automatic logic [PRESS_W-1:0] conflict_supp(
    input logic [PRESS_W-1:0] pressed,
    input logic [MASK_W-1:0]  mask
  );
    logic [PRESS_W-1:0] s;
    s = '0;
    s[ACT_ACCEPT] = (mask[CM_ACCEPT_BACK] & pressed[ACT_BACK]) |
                    (mask[CM_ACCEPT_START] & pressed[ACT_START]);
    s[ACT_BACK]   = mask[CM_ACCEPT_BACK] & pressed[ACT_ACCEPT];
    s[ACT_UP]     = mask[CM_UP_DOWN] & pressed[ACT_DOWN];
    s[ACT_DOWN]   = mask[CM_UP_DOWN] & pressed[ACT_UP];
    s[ACT_LEFT]   = mask[CM_LEFT_RIGHT] & pressed[ACT_RIGHT];
    s[ACT_RIGHT]  = mask[CM_LEFT_RIGHT] & pressed[ACT_LEFT];
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: design/bac_lane.sv
// one action lane: held/first flags, last fire time and the repeat decision
// depends on bac_pkg
`default_nettype none

module bac_lane (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire bac_pkg::bac_lane_ctl_t ctl,
  input  wire                         pressed,
  input  wire                         supp,
  output logic                        fire
);
  import bac_pkg::*;

  logic              held_r, held_nxt;
  logic              first_r, first_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;

  logic [TIME_W-1:0]  elapsed;
  logic [DELAY_W-1:0] limit;
  logic               not_due;

  // hold timer compare
  assign elapsed = ctl.now - last_r;
  assign limit   = first_r ? ctl.init_delay : ctl.repeat_ivl;
  assign not_due = held_r && (elapsed <= {{(TIME_W-DELAY_W){1'b0}}, limit});

  // next state and fire decision
  always_comb begin
    held_nxt  = held_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    fire      = 1'b0;
    if (ctl.upd) begin
      if (ctl.rearm) begin
        held_nxt  = 1'b1;
        first_nxt = 1'b1;
        last_nxt  = ctl.now;
      end else if (ctl.active) begin
        if (not_due) begin
          if (!pressed) held_nxt = 1'b0;
        end else if (pressed) begin
          fire      = !supp;
          first_nxt = !held_r;
          last_nxt  = ctl.now;
          held_nxt  = 1'b1;
        end else begin
          held_nxt = 1'b0;
        end
      end
    end
  end

  // flags reset, time only read once held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 1'b0;
      first_r <= 1'b0;
    end else begin
      held_r  <= held_nxt;
      first_r <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
  end

endmodule

`default_nettype wire

FILE: design/button_autorepeat_with_conflict_mask_core.sv
// button autorepeat core: input register, per-action lanes, result register
// an accepted word goes through the input register, then the result register, to out_
// throughput: one word per cycle unless stalled; set by the lanes' single update pass
// reset: synchronous active low; flags clear, registers return to 500/150/7
// depends on bac_pkg and bac_lane
`default_nettype none

module button_autorepeat_with_conflict_mask_core #(
  parameter int ACTION_COUNT = bac_pkg::ACTION_COUNT_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire [bac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [bac_pkg::CFG_DAT_W-1:0]     cfg_wdata,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              in_mode,
  input  wire [bac_pkg::TIME_W-1:0]        in_now_ms,
  input  wire [bac_pkg::PRESS_W-1:0]       in_pressed_bits,
  input  wire                              in_active,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [bac_pkg::PRESS_W-1:0]      out_fired_bits
);
  import bac_pkg::*;

  // configuration registers
  logic [DELAY_W-1:0] init_delay_r;
  logic [DELAY_W-1:0] repeat_ivl_r;
  logic [MASK_W-1:0]  conflict_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_delay_r <= INIT_DELAY_RST;
      repeat_ivl_r <= REPEAT_IVL_RST;
      conflict_r   <= CONFLICT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INIT_DELAY: init_delay_r <= cfg_wdata[DELAY_W-1:0];
        CFG_REPEAT_IVL: repeat_ivl_r <= cfg_wdata[DELAY_W-1:0];
        CFG_CONFLICT:   conflict_r   <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // input register and handshake
  logic               s1_v_r;
  logic               s1_mode_r;
  logic [TIME_W-1:0]  s1_now_r;
  logic [PRESS_W-1:0] s1_press_r;
  logic               s1_act_r;
  logic               out_v_r;
  logic [PRESS_W-1:0] out_fired_r, out_fired_nxt;
  logic               adv, move;

  assign adv      = !out_v_r || !out_stall;
  assign move     = s1_v_r && adv;
  assign in_stall = s1_v_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!in_stall) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_mode_r  <= in_mode;
      s1_now_r   <= in_now_ms;
      s1_press_r <= in_pressed_bits;
      s1_act_r   <= in_active;
    end
  end

  // pressed bits of existing actions only, and their conflicts
  logic [PRESS_W-1:0]      press_m;
  logic [PRESS_W-1:0]      supp;
  logic [ACTION_COUNT-1:0] lane_press, lane_supp, lane_fire;
  bac_lane_ctl_t           ctl;

  genvar g;
  generate
    for (g = 0; g < PRESS_W; g++) begin : g_pmask
      if (g < ACTION_COUNT) begin : g_in
        assign press_m[g] = s1_press_r[g];
      end else begin : g_out
        assign press_m[g] = 1'b0;
      end
    end
  endgenerate

  assign supp = conflict_supp(press_m, conflict_r);

  assign ctl.upd        = move;
  assign ctl.rearm      = s1_mode_r;
  assign ctl.active     = s1_act_r;
  assign ctl.now        = s1_now_r;
  assign ctl.init_delay = init_delay_r;
  assign ctl.repeat_ivl = repeat_ivl_r;

  // one lane per action; actions past the pressed field are never pressed
  generate
    for (g = 0; g < ACTION_COUNT; g++) begin : g_lane
      if (g < PRESS_W) begin : g_vis
        assign lane_press[g] = press_m[g];
        assign lane_supp[g]  = supp[g];
      end else begin : g_hid
        assign lane_press[g] = 1'b0;
        assign lane_supp[g]  = 1'b0;
      end
      bac_lane u_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .pressed (lane_press[g]),
        .supp    (lane_supp[g]),
        .fire    (lane_fire[g])
      );
    end
    for (g = 0; g < PRESS_W; g++) begin : g_fout
      if (g < ACTION_COUNT) begin : g_in
        assign out_fired_nxt[g] = lane_fire[g];
      end else begin : g_out
        assign out_fired_nxt[g] = 1'b0;
      end
    end
  endgenerate

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_fired_r <= out_fired_nxt;
    end
  end

  assign out_valid      = out_v_r;
  assign out_fired_bits = out_fired_r;

endmodule

`default_nettype wire
